// ===== design/dsm_pkg.sv =====
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types and constants for the dual stream saturating mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package dsm_pkg;

  // stream select carried with each input beat
  localparam logic OP_MAIN = 1'b0;
  localparam logic OP_COP  = 1'b1;

  // register map
  localparam int unsigned CFG_ADDR_W     = 2;
  localparam int unsigned REG_MIX_ENABLE = 0;

  // result queue in front of the output port
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = 2;
  localparam int unsigned OUTQ_LW    = 3;

  typedef logic [15:0] sample_t;

  // left in the low half, right in the high half
  typedef struct packed {
    sample_t right;
    sample_t left;
  } pair_t;

  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } ring_ctrl_t;

endpackage : dsm_pkg

`default_nettype wire

// ===== design/dsm_ring.sv =====
// ----------------------------------------------------------------------------
// dsm_ring
// Ring buffer of stereo pairs with wrapping fill count and registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dsm_ring #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dsm_pkg::ring_ctrl_t ctrl,
  input  wire dsm_pkg::pair_t     push_data,
  output logic [AW-1:0]           fill_post,
  output dsm_pkg::pair_t          rd_data
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  dsm_pkg::pair_t mem [DEPTH];

  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]  fill_r,   fill_nxt;
  dsm_pkg::pair_t mem_q_r;
  dsm_pkg::pair_t byp_r;
  logic           byp_sel_r;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v);
    return (v == LAST) ? '0 : v + AW'(1);
  endfunction

  // fill after this beat's push; a pop is only issued when this is non-zero
  assign fill_post = ctrl.push ? wrap_inc(fill_r) : fill_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_post;
    if (ctrl.clr) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      fill_nxt   = '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr_nxt = wrap_inc(wr_ptr_r);
      end
      if (ctrl.pop) begin
        rd_ptr_nxt = wrap_inc(rd_ptr_r);
        fill_nxt   = fill_post - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clr) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // a pop of the entry being written this cycle takes the incoming pair
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      mem_q_r   <= mem[rd_ptr_r];
      byp_r     <= push_data;
      byp_sel_r <= ctrl.push && (wr_ptr_r == rd_ptr_r);
    end
  end

  assign rd_data = byp_sel_r ? byp_r : mem_q_r;

endmodule : dsm_ring

`default_nettype wire

// ===== design/dsm_lane.sv =====
// ----------------------------------------------------------------------------
// dsm_lane
// One channel lane: signed 16-bit add with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module dsm_lane (
  input  wire dsm_pkg::sample_t a,
  input  wire dsm_pkg::sample_t b,
  output dsm_pkg::sample_t      y
);

  logic [16:0] sum;

  assign sum = {a[15], a} + {b[15], b};

  // top two bits disagree only on overflow; the sign bit says which way
  always_comb begin
    if (sum[16] != sum[15]) begin
      y = sum[16] ? 16'h8000 : 16'h7FFF;
    end else begin
      y = sum[15:0];
    end
  end

endmodule : dsm_lane

`default_nettype wire

// ===== design/dsm_outq.sv =====
// ----------------------------------------------------------------------------
// dsm_outq
// Merging stage: collects the lane results into a small result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dsm_outq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire dsm_pkg::sample_t left,
  input  wire dsm_pkg::sample_t right,
  input  wire logic           rd_en,
  output logic                not_empty,
  output dsm_pkg::pair_t      head,
  output logic [dsm_pkg::OUTQ_LW-1:0] level
);

  dsm_pkg::pair_t q_r [dsm_pkg::OUTQ_DEPTH];

  logic [dsm_pkg::OUTQ_AW-1:0] wr_ptr_r;
  logic [dsm_pkg::OUTQ_AW-1:0] rd_ptr_r;
  logic [dsm_pkg::OUTQ_LW-1:0] level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (wr_en && !rd_en) begin
      level_nxt = level_r + dsm_pkg::OUTQ_LW'(1);
    end else if (!wr_en && rd_en) begin
      level_nxt = level_r - dsm_pkg::OUTQ_LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      level_r <= level_nxt;
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + dsm_pkg::OUTQ_AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + dsm_pkg::OUTQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= '{right: right, left: left};
    end
  end

  assign not_empty = (level_r != '0);
  assign head      = q_r[rd_ptr_r];
  assign level     = level_r;

endmodule : dsm_outq

`default_nettype wire

// ===== design/dual_stream_saturating_mixer_core.sv =====
// A beat with a result is registered for the lanes, then written to the result queue.
// One beat per cycle unless stalled; each ring takes one write and one read a cycle.
// in_stall rises only when the four-entry result queue plus the beat in flight are full.
// Reset clears ring pointers, fill counts, mix_enable and the result queue.
// Ring contents are not cleared; a write to mix_enable empties both rings.
// ----------------------------------------------------------------------------
// dual_stream_saturating_mixer_core
// Mixes a main and a coprocessor stereo stream with per-channel saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_stream_saturating_mixer_core #(
  parameter int unsigned RING_DEPTH = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_op,
  input  wire logic signed [15:0]             in_left_in,
  input  wire logic signed [15:0]             in_right_in,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [15:0]                  out_left_out,
  output logic signed [15:0]                  out_right_out,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [dsm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                    cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic                 cfg_wr;
  logic                 mix_en_r;
  logic                 accept;
  logic                 is_pass;
  logic                 pop;
  dsm_pkg::ring_ctrl_t  m_ctrl, c_ctrl;
  dsm_pkg::pair_t       in_pair;
  dsm_pkg::pair_t       m_rd, c_rd;
  logic [AW-1:0]        m_fill_post, c_fill_post;

  logic                 vb_r;
  logic                 pass_r;
  dsm_pkg::pair_t       pass_data_r;

  dsm_pkg::sample_t     lane_l_a, lane_l_b, lane_r_a, lane_r_b;
  dsm_pkg::sample_t     mix_l, mix_r;
  dsm_pkg::pair_t       q_head;
  logic [dsm_pkg::OUTQ_LW-1:0] q_level;
  logic                 q_rd;

  // ---- configuration ----
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // single register; every address decodes to it
  assign cfg_prdata = (cfg_paddr == dsm_pkg::CFG_ADDR_W'(dsm_pkg::REG_MIX_ENABLE))
                      ? {31'd0, mix_en_r} : {31'd0, mix_en_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_en_r <= 1'b0;
    end else if (cfg_wr) begin
      mix_en_r <= cfg_pwdata[0];
    end
  end

  // ---- accept stage: ring pushes and pop decision ----
  assign in_stall = ({1'b0, q_level} + {{dsm_pkg::OUTQ_LW{1'b0}}, vb_r})
                    >= (dsm_pkg::OUTQ_LW + 1)'(dsm_pkg::OUTQ_DEPTH);
  assign accept   = in_valid && !in_stall;
  assign is_pass  = (in_op == dsm_pkg::OP_MAIN) && !mix_en_r;
  assign in_pair  = '{right: in_right_in, left: in_left_in};

  assign m_ctrl.clr  = cfg_wr;
  assign m_ctrl.push = accept && (in_op == dsm_pkg::OP_MAIN) && mix_en_r;
  assign c_ctrl.clr  = cfg_wr;
  assign c_ctrl.push = accept && (in_op == dsm_pkg::OP_COP);

  assign pop = (m_ctrl.push || c_ctrl.push) && (m_fill_post != '0) && (c_fill_post != '0);
  assign m_ctrl.pop = pop;
  assign c_ctrl.pop = pop;

  dsm_ring #(.DEPTH(RING_DEPTH), .AW(AW)) u_main_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (m_ctrl),
    .push_data (in_pair),
    .fill_post (m_fill_post),
    .rd_data   (m_rd)
  );

  dsm_ring #(.DEPTH(RING_DEPTH), .AW(AW)) u_cop_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (c_ctrl),
    .push_data (in_pair),
    .fill_post (c_fill_post),
    .rd_data   (c_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= accept && (is_pass || pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pass_r      <= is_pass;
      pass_data_r <= in_pair;
    end
  end

  // ---- lanes: pass-through adds zero, so it saturates to itself ----
  assign lane_l_a = pass_r ? pass_data_r.left  : m_rd.left;
  assign lane_r_a = pass_r ? pass_data_r.right : m_rd.right;
  assign lane_l_b = pass_r ? '0 : c_rd.left;
  assign lane_r_b = pass_r ? '0 : c_rd.right;

  dsm_lane u_lane_left (
    .a (lane_l_a),
    .b (lane_l_b),
    .y (mix_l)
  );

  dsm_lane u_lane_right (
    .a (lane_r_a),
    .b (lane_r_b),
    .y (mix_r)
  );

  // ---- merge into result queue ----
  assign q_rd = out_valid && !out_stall;

  dsm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (vb_r),
    .left      (mix_l),
    .right     (mix_r),
    .rd_en     (q_rd),
    .not_empty (out_valid),
    .head      (q_head),
    .level     (q_level)
  );

  assign out_left_out  = q_head.left;
  assign out_right_out = q_head.right;

endmodule : dual_stream_saturating_mixer_core

`default_nettype wire

// ===== design/dsm_checker.sv =====
// ----------------------------------------------------------------------------
// dsm_checker
// Port-level checks for the mixer core, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dsm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_op,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_left_out,
  input wire logic [15:0] out_right_out,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pwrite,
  input wire logic [31:0] cfg_pwdata,
  input wire logic        cfg_pready
);

  logic mix_en_r;
  logic in_beat;

  // shadow of mix_enable, tracked from port writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_en_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      mix_en_r <= cfg_pwdata[0];
    end
  end

  assign in_beat = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_out) && $stable(out_right_out))
    else $error("stalled output beat changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high straight after reset");

  a_pass_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_op == dsm_pkg::OP_MAIN) && !mix_en_r |=> ##1 out_valid)
    else $error("pass-through beat did not reach the output");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("pready low during access");

endmodule : dsm_checker

bind dual_stream_saturating_mixer_core dsm_checker u_dsm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_left_out  (out_left_out),
  .out_right_out (out_right_out),
  .cfg_psel      (cfg_psel),
  .cfg_penable   (cfg_penable),
  .cfg_pwrite    (cfg_pwrite),
  .cfg_pwdata    (cfg_pwdata),
  .cfg_pready    (cfg_pready)
);

`default_nettype wire

// ===== test/tb_dual_stream_saturating_mixer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_stream_saturating_mixer_core
// Self-checking bench for the saturating two-stream mixer. A directed script
// is followed by random passthrough and mixing phases and a receiver
// hold-off. Each result is checked against an in-bench model or a pinned row.
// ----------------------------------------------------------------------------
module tb_dual_stream_saturating_mixer_core;

  localparam int unsigned RING_DEPTH      = 4096;
  localparam int unsigned PTR_W           = $clog2(RING_DEPTH);
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned REPORT_CAP      = 40;
  localparam int unsigned SCRIPT_ROWS     = 26;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             op;
    logic             en;
    dsm_pkg::sample_t left;
    dsm_pkg::sample_t right;
    logic             pinned;
    dsm_pkg::sample_t exp_left;
    dsm_pkg::sample_t exp_right;
  } script_row_t;

  // pinned rows carry a result that can be read straight off the arithmetic
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'hFFFF, 16'h0001, 1'b1, 16'hFFFF, 16'h0001},
    '{ROW_BEAT, dsm_pkg::OP_COP,  1'b0, 16'h04D2, 16'hFFFB, 1'b0, 16'h0000, 16'h0000},
    '{ROW_CFG,  dsm_pkg::OP_MAIN, 1'b1, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{ROW_BEAT, dsm_pkg::OP_COP,  1'b0, 16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF, 16'h7FFF},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_BEAT, dsm_pkg::OP_COP,  1'b0, 16'h8000, 16'h8000, 1'b1, 16'h8000, 16'h8000},
    '{ROW_BEAT, dsm_pkg::OP_COP,  1'b0, 16'h0064, 16'hFF9C, 1'b0, 16'h0000, 16'h0000},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'hFFCE, 16'h0032, 1'b1, 16'h0032, 16'hFFCE},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_BEAT, dsm_pkg::OP_COP,  1'b0, 16'h8000, 16'h7FFF, 1'b1, 16'hFFFF, 16'hFFFF},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'h4000, 16'hC000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'h4000, 16'hBFFF, 1'b0, 16'h0000, 16'h0000},
    '{ROW_BEAT, dsm_pkg::OP_COP,  1'b0, 16'h4000, 16'hC000, 1'b1, 16'h7FFF, 16'h8000},
    '{ROW_BEAT, dsm_pkg::OP_COP,  1'b0, 16'h3FFF, 16'hC000, 1'b1, 16'h7FFF, 16'h8000},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'h0005, 16'h0005, 1'b0, 16'h0000, 16'h0000},
    '{ROW_CFG,  dsm_pkg::OP_MAIN, 1'b1, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_BEAT, dsm_pkg::OP_COP,  1'b0, 16'h0007, 16'h0007, 1'b0, 16'h0000, 16'h0000},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'h0001, 16'h0002, 1'b1, 16'h0008, 16'h0009},
    '{ROW_CFG,  dsm_pkg::OP_MAIN, 1'b0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'h5555, 16'hAAAA, 1'b1, 16'h5555, 16'hAAAA},
    '{ROW_BEAT, dsm_pkg::OP_MAIN, 1'b0, 16'hAAAA, 16'h5555, 1'b1, 16'hAAAA, 16'h5555},
    '{ROW_BEAT, dsm_pkg::OP_COP,  1'b0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_op;
  logic signed [15:0] in_left_in;
  logic signed [15:0] in_right_in;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_left_out;
  logic signed [15:0] out_right_out;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [dsm_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // bench-side tag travelling with each beat
  logic           pin_valid;
  dsm_pkg::pair_t pin_pair;

  // mixer model state
  dsm_pkg::pair_t main_store [RING_DEPTH];
  dsm_pkg::pair_t cop_store  [RING_DEPTH];
  logic [PTR_W-1:0] main_wr, main_rd, main_cnt;
  logic [PTR_W-1:0] cop_wr, cop_rd, cop_cnt;
  logic mix_on;

  dsm_pkg::pair_t mixed_due [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int burst_left;
  bit hold_off_req = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dual_stream_saturating_mixer_core #(
    .RING_DEPTH(RING_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  task automatic flag_mismatch(input string what);
    if (mismatches < REPORT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatches++;
  endtask

  function automatic dsm_pkg::sample_t sat_sum(dsm_pkg::sample_t a, dsm_pkg::sample_t b);
    logic signed [16:0] s;
    s = $signed({a[15], a}) + $signed({b[15], b});
    if (s > 17'sd32767) begin
      return 16'h7FFF;
    end
    if (s < -17'sd32768) begin
      return 16'h8000;
    end
    return s[15:0];
  endfunction

  // one beat into the model; counters wrap at the ring depth like the pointers
  task automatic mixer_predict(input logic op, input dsm_pkg::pair_t beat,
                               output bit got, output dsm_pkg::pair_t mixed);
    got = 1'b0;
    mixed = '0;
    if (op == dsm_pkg::OP_MAIN && !mix_on) begin
      got = 1'b1;
      mixed = beat;
    end else begin
      if (op == dsm_pkg::OP_MAIN) begin
        main_store[main_wr] = beat;
        main_wr = main_wr + 1'b1;
        main_cnt = main_cnt + 1'b1;
      end else begin
        cop_store[cop_wr] = beat;
        cop_wr = cop_wr + 1'b1;
        cop_cnt = cop_cnt + 1'b1;
      end
      if (main_cnt != 0 && cop_cnt != 0) begin
        mixed.left  = sat_sum(main_store[main_rd].left, cop_store[cop_rd].left);
        mixed.right = sat_sum(main_store[main_rd].right, cop_store[cop_rd].right);
        main_rd = main_rd + 1'b1;
        cop_rd = cop_rd + 1'b1;
        main_cnt = main_cnt - 1'b1;
        cop_cnt = cop_cnt - 1'b1;
        got = 1'b1;
      end
    end
  endtask

  task automatic clear_model_rings();
    main_wr = '0;
    main_rd = '0;
    main_cnt = '0;
    cop_wr = '0;
    cop_rd = '0;
    cop_cnt = '0;
  endtask

  always @(posedge clk) begin : scoreboard
    bit got;
    dsm_pkg::pair_t mixed;
    dsm_pkg::pair_t want;
    if (rst_n && in_valid && !in_stall) begin
      mixer_predict(in_op, dsm_pkg::pair_t'({in_right_in, in_left_in}), got, mixed);
      if (pin_valid) begin
        if (!got) begin
          flag_mismatch("model gives no result for a pinned beat");
        end
        mixed = pin_pair;
      end
      if (got) begin
        mixed_due.push_back(mixed);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (mixed_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat %h/%h", out_left_out, out_right_out));
      end else begin
        want = mixed_due.pop_front();
        if (out_left_out !== want.left) begin
          flag_mismatch($sformatf("left_out %h, want %h", out_left_out, want.left));
        end
        if (out_right_out !== want.right) begin
          flag_mismatch($sformatf("right_out %h, want %h", out_right_out, want.right));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: stall mode is redrawn at random after each span of random length
  initial begin : receiver
    rx_mode_t mode;
    int span;
    int tick;
    out_stall = 1'b0;
    tick = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(32, 256);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            RX_FREE:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
            RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default:  out_stall <= ((tick % 5) < 2);
          endcase
        end
      end
    end
  end

  function automatic int next_burst();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(40, 120);
    end
    return $urandom_range(1, 16);
  endfunction

  function automatic dsm_pkg::sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return dsm_pkg::sample_t'($urandom_range(0, 3));
      3:       return 16'hFFFF - dsm_pkg::sample_t'($urandom_range(0, 3));
      default: return dsm_pkg::sample_t'($urandom());
    endcase
  endfunction

  // holds the beat until it is taken, then maybe opens a gap
  task automatic offer_beat(input logic op, input dsm_pkg::sample_t l,
                            input dsm_pkg::sample_t r,
                            input logic pin, input dsm_pkg::pair_t pinned);
    int gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_left_in <= l;
    in_right_in <= r;
    pin_valid <= pin;
    pin_pair <= pinned;
    do @(posedge clk); while (!(in_valid && !in_stall));
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = next_burst();
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (mixed_due.size() != 0);
    // beats that yield nothing may still be in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mix_enable(input logic en);
    logic [30:0] junk;
    logic [31:0] rd;
    junk = $urandom();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= dsm_pkg::CFG_ADDR_W'(4 * dsm_pkg::REG_MIX_ENABLE);
    cfg_pwdata <= {junk, en};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    mix_on = en;
    clear_model_rings();
    // straight into a read-back
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== {31'b0, en}) begin
      flag_mismatch($sformatf("mix_enable reads %h, want %h", rd, en));
    end
  endtask

  // random interleave of both streams, with the odd lopsided run
  task automatic stream_mixed(input int n);
    int k;
    int run;
    logic op;
    k = 0;
    while (k < n) begin
      op = $urandom_range(0, 1);
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 12) : 1;
      repeat (run) begin
        offer_beat(op, pick_sample(), pick_sample(), 1'b0, '0);
        k++;
      end
    end
  endtask

  task automatic stream_passthrough(input int n);
    logic op;
    repeat (n) begin
      op = ($urandom_range(0, 4) == 0) ? dsm_pkg::OP_COP : dsm_pkg::OP_MAIN;
      offer_beat(op, pick_sample(), pick_sample(), 1'b0, '0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = dsm_pkg::OP_MAIN;
    in_left_in = '0;
    in_right_in = '0;
    pin_valid = 1'b0;
    pin_pair = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mix_on = 1'b0;
    clear_model_rings();
    burst_left = next_burst();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        quiesce();
        write_mix_enable(SCRIPT[i].en);
      end else begin
        offer_beat(SCRIPT[i].op, SCRIPT[i].left, SCRIPT[i].right, SCRIPT[i].pinned,
                   {SCRIPT[i].exp_right, SCRIPT[i].exp_left});
      end
    end

    quiesce();
    write_mix_enable(1'b1);
    stream_mixed(200);

    quiesce();
    write_mix_enable(1'b0);
    stream_passthrough(70);
    // receiver backs off while main beats keep coming, so the input stalls
    hold_off_req = 1'b1;
    repeat (80) offer_beat(dsm_pkg::OP_MAIN, pick_sample(), pick_sample(), 1'b0, '0);
    stream_passthrough(70);

    quiesce();
    write_mix_enable(1'b1);
    stream_mixed(200);

    quiesce();
    write_mix_enable(1'b1);
    stream_mixed(200);

    quiesce();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
